>>> src/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg
// Shared types and constants of the alpha-beta nearest target tracker.
// ----------------------------------------------------------------------------
package abt_pkg;

  localparam int GAIN_W     = 9;
  localparam int GATE_W     = 16;
  localparam int MISS_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_POS_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_VEL_GAIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_VEL_DECAY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GATE_DIST  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MISS_LIMIT = 3'd4;

  localparam logic [GAIN_W-1:0] POS_GAIN_RST   = 9'd154;
  localparam logic [GAIN_W-1:0] VEL_GAIN_RST   = 9'd26;
  localparam logic [GAIN_W-1:0] VEL_DECAY_RST  = 9'd230;
  localparam logic [GATE_W-1:0] GATE_DIST_RST  = 16'd512;
  localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 8'd10;
  localparam logic [MISS_W-1:0] MISS_MAX       = 8'd255;

  typedef enum logic [1:0] {
    UPD_IDLE,
    UPD_DIFF,
    UPD_MULT,
    UPD_APPLY
  } upd_state_t;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_COAST,
    MODE_DROP,
    MODE_INIT,
    MODE_GATED,
    MODE_FILTER
  } mode_t;

  // frame-end record from the nearest-point search to the update unit
  typedef struct packed {
    logic valid;
    logic has_point;
  } frame_ctl_t;

  // track status from the update unit back to the search
  typedef struct packed {
    logic tracking;
    logic idle;
  } trk_status_t;

  // squared distance width, saturated at 64 bits
  function automatic int dist_width(input int cw);
    return (2 * cw + 1 > 64) ? 64 : 2 * cw + 1;
  endfunction

endpackage

>>> src/abt_front.sv
// ----------------------------------------------------------------------------
// abt_front
// Input side: accepts beats, drops point-less beats inside a frame and
// queues the rest for the back end.
// ----------------------------------------------------------------------------
module abt_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_px,
  input  logic signed [COORD_WIDTH-1:0] in_py,
  input  logic signed [COORD_WIDTH-1:0] in_sx,
  input  logic signed [COORD_WIDTH-1:0] in_sy,
  input  logic                          in_has,
  input  logic                          in_last,
  input  logic                          pop,
  output logic                          q_valid,
  output logic signed [COORD_WIDTH-1:0] q_px,
  output logic signed [COORD_WIDTH-1:0] q_py,
  output logic signed [COORD_WIDTH-1:0] q_sx,
  output logic signed [COORD_WIDTH-1:0] q_sy,
  output logic                          q_has,
  output logic                          q_last
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int IW    = 4 * COORD_WIDTH + 2;

  logic [IW-1:0]    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;
  logic             push;
  logic [IW-1:0]    head;

  assign in_ready = (count_r != (PTR_W+1)'(DEPTH));
  // a point-less beat that does not close a frame has no effect
  assign push     = in_valid & in_ready & (in_has | in_last);
  assign q_valid  = (count_r != '0);

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= {in_sy, in_sx, in_py, in_px, in_last, in_has};
    end
  end

  assign head   = mem_r[rd_ptr_r];
  assign q_has  = head[0];
  assign q_last = head[1];
  assign q_px   = head[2+:COORD_WIDTH];
  assign q_py   = head[2+COORD_WIDTH+:COORD_WIDTH];
  assign q_sx   = head[2+2*COORD_WIDTH+:COORD_WIDTH];
  assign q_sy   = head[2+3*COORD_WIDTH+:COORD_WIDTH];

endmodule

>>> src/abt_nearest.sv
// ----------------------------------------------------------------------------
// abt_nearest
// Nearest-point search: three-stage squared-distance pipeline and running
// minimum over one frame; issues the frame record at frame end.
// ----------------------------------------------------------------------------
module abt_nearest
  import abt_pkg::*;
#(
  parameter  int COORD_WIDTH = 16,
  localparam int DW          = dist_width(COORD_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop,
  input  logic signed [COORD_WIDTH-1:0] q_px,
  input  logic signed [COORD_WIDTH-1:0] q_py,
  input  logic signed [COORD_WIDTH-1:0] q_sx,
  input  logic signed [COORD_WIDTH-1:0] q_sy,
  input  logic                          q_has,
  input  logic                          q_last,
  input  trk_status_t                   trk,
  input  logic signed [COORD_WIDTH-1:0] ref_x,
  input  logic signed [COORD_WIDTH-1:0] ref_y,
  output frame_ctl_t                    frm_ctl,
  output logic signed [COORD_WIDTH-1:0] frm_x,
  output logic signed [COORD_WIDTH-1:0] frm_y,
  output logic [DW-1:0]                 frm_dist
);

  localparam int DFW   = COORD_WIDTH + 1;
  localparam int SQW   = 2 * COORD_WIDTH;
  localparam int SUM_W = 2 * COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] rx, ry;

  logic                          s1_valid_r, s1_has_r, s1_last_r;
  logic signed [DFW-1:0]         s1_dx_r, s1_dy_r;
  logic signed [COORD_WIDTH-1:0] s1_px_r, s1_py_r;

  logic signed [2*DFW-1:0]       sqx_full, sqy_full;
  logic                          s2_valid_r, s2_has_r, s2_last_r;
  logic [SQW-1:0]                s2_sqx_r, s2_sqy_r;
  logic signed [COORD_WIDTH-1:0] s2_px_r, s2_py_r;

  logic [SUM_W-1:0]              sum;
  logic [DW-1:0]                 cur_dsq;
  logic                          take;

  logic                          fhp_r;
  logic [DW-1:0]                 best_d_r;
  logic signed [COORD_WIDTH-1:0] best_x_r, best_y_r;
  frame_ctl_t                    frm_ctl_r;
  logic signed [COORD_WIDTH-1:0] frm_x_r, frm_y_r;
  logic [DW-1:0]                 frm_d_r;

  // reference: own pose until a track exists, the estimate afterwards
  assign rx = trk.tracking ? ref_x : q_sx;
  assign ry = trk.tracking ? ref_y : q_sy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= pop;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign sqx_full = s1_dx_r * s1_dx_r;
  assign sqy_full = s1_dy_r * s1_dy_r;

  always_ff @(posedge clk) begin
    s1_dx_r   <= DFW'(q_px) - DFW'(rx);
    s1_dy_r   <= DFW'(q_py) - DFW'(ry);
    s1_px_r   <= q_px;
    s1_py_r   <= q_py;
    s1_has_r  <= q_has;
    s1_last_r <= q_last;
    s2_sqx_r  <= sqx_full[SQW-1:0];
    s2_sqy_r  <= sqy_full[SQW-1:0];
    s2_px_r   <= s1_px_r;
    s2_py_r   <= s1_py_r;
    s2_has_r  <= s1_has_r;
    s2_last_r <= s1_last_r;
  end

  always_comb begin
    sum = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
    if ((sum >> DW) != '0) cur_dsq = '1;
    else                   cur_dsq = sum[DW-1:0];
  end

  // strict compare: the first point keeps a tie
  assign take = s2_valid_r & s2_has_r & (~fhp_r | (cur_dsq < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fhp_r     <= 1'b0;
      best_d_r  <= '1;
      best_x_r  <= '0;
      best_y_r  <= '0;
      frm_ctl_r <= '0;
    end else begin
      if (s2_valid_r && s2_last_r) begin
        frm_ctl_r <= frame_ctl_t'{valid: 1'b1, has_point: fhp_r | s2_has_r};
        fhp_r     <= 1'b0;
        best_d_r  <= '1;
      end else begin
        frm_ctl_r <= '0;
        if (take) begin
          fhp_r    <= 1'b1;
          best_d_r <= cur_dsq;
          best_x_r <= s2_px_r;
          best_y_r <= s2_py_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_last_r) begin
      frm_x_r <= take ? s2_px_r : best_x_r;
      frm_y_r <= take ? s2_py_r : best_y_r;
      frm_d_r <= take ? cur_dsq : best_d_r;
    end
  end

  assign frm_ctl  = frm_ctl_r;
  assign frm_x    = frm_x_r;
  assign frm_y    = frm_y_r;
  assign frm_dist = frm_d_r;

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    frm_ctl_r.valid |-> !fhp_r)
    else $error("search state not cleared at frame end");

endmodule

>>> src/abt_update.sv
// ----------------------------------------------------------------------------
// abt_update
// Frame-end update: classifies the frame, then residual, gain multiply and
// round/saturate steps; owns the track state and the result register.
// ----------------------------------------------------------------------------
module abt_update
  import abt_pkg::*;
#(
  parameter  int COORD_WIDTH = 16,
  localparam int DW          = dist_width(COORD_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  frame_ctl_t                    frm_ctl,
  input  logic signed [COORD_WIDTH-1:0] frm_x,
  input  logic signed [COORD_WIDTH-1:0] frm_y,
  input  logic [DW-1:0]                 frm_dist,
  input  logic [GAIN_W-1:0]             pos_gain,
  input  logic [GAIN_W-1:0]             vel_gain,
  input  logic [GAIN_W-1:0]             vel_decay,
  input  logic [2*GATE_W-1:0]           gate_sq,
  input  logic [MISS_W-1:0]             miss_limit,
  output trk_status_t                   trk,
  output logic signed [COORD_WIDTH-1:0] est_x,
  output logic signed [COORD_WIDTH-1:0] est_y,
  output logic                          done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_track_valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_vx,
  output logic signed [COORD_WIDTH-1:0] out_vy
);

  localparam int CMP_W = (DW > 2 * GATE_W) ? DW : 2 * GATE_W;
  localparam int RW    = COORD_WIDTH + 2;
  localparam int PW    = COORD_WIDTH + 12;
  localparam logic signed [PW-1:0] RND   = PW'(128);
  localparam logic signed [PW-1:0] C_MAX = PW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic signed [PW-1:0] C_MIN = ~C_MAX;

  upd_state_t                    state_r, state_nxt;
  mode_t                         mode_r, mode_cap;
  logic                          tracking_r;
  logic [MISS_W-1:0]             miss_r, miss_inc;
  logic signed [COORD_WIDTH-1:0] pos_r [2];
  logic signed [COORD_WIDTH-1:0] vel_r [2];
  logic signed [COORD_WIDTH-1:0] obs_r [2];
  logic signed [COORD_WIDTH:0]   pred_r [2];
  logic signed [RW-1:0]          res_r [2];
  logic signed [PW-1:0]          ppos_r [2];
  logic signed [PW-1:0]          pvel_r [2];
  logic signed [PW-1:0]          pdec_r [2];
  logic signed [GAIN_W:0]        pos_gain_s, vel_gain_s, decay_s;
  logic signed [COORD_WIDTH-1:0] new_pos [2];
  logic signed [COORD_WIDTH-1:0] new_vel [2];
  logic                          idle, has_result, commit;
  logic                          out_valid_r, out_tv_r;
  logic signed [COORD_WIDTH-1:0] out_pos_r [2];
  logic signed [COORD_WIDTH-1:0] out_vel_r [2];

  function automatic logic signed [COORD_WIDTH-1:0] sat_c(input logic signed [PW-1:0] v);
    if (v > C_MAX)      return C_MAX[COORD_WIDTH-1:0];
    else if (v < C_MIN) return C_MIN[COORD_WIDTH-1:0];
    else                return v[COORD_WIDTH-1:0];
  endfunction

  assign miss_inc = (miss_r == MISS_MAX) ? MISS_MAX : miss_r + 1'b1;

  always_comb begin
    if (!frm_ctl.has_point) begin
      if (!tracking_r)             mode_cap = MODE_HOLD;
      else if (miss_inc < miss_limit) mode_cap = MODE_COAST;
      else                         mode_cap = MODE_DROP;
    end else if (!tracking_r) begin
      mode_cap = MODE_INIT;
    end else if (CMP_W'(frm_dist) > CMP_W'(gate_sq)) begin
      mode_cap = MODE_GATED;
    end else begin
      mode_cap = MODE_FILTER;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      UPD_IDLE:  if (frm_ctl.valid) state_nxt = UPD_DIFF;
      UPD_DIFF:  state_nxt = UPD_MULT;
      UPD_MULT:  state_nxt = UPD_APPLY;
      UPD_APPLY: if (commit) state_nxt = UPD_IDLE;
      default:   state_nxt = UPD_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    idle       = (state_r == UPD_IDLE);
    has_result = (mode_r != MODE_INIT);
    commit     = (state_r == UPD_APPLY) &&
                 (!has_result || !out_valid_r || out_ready);
  end

  // residual obs - (x + v) serves both the position and the velocity gain
  assign pos_gain_s = {1'b0, pos_gain};
  assign vel_gain_s = {1'b0, vel_gain};
  assign decay_s    = {1'b0, vel_decay};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      pred_r[i] <= (COORD_WIDTH+1)'(pos_r[i]) + (COORD_WIDTH+1)'(vel_r[i]);
      res_r[i]  <= RW'(obs_r[i]) - RW'(pos_r[i]) - RW'(vel_r[i]);
      ppos_r[i] <= PW'(res_r[i]) * PW'(pos_gain_s);
      pvel_r[i] <= PW'(res_r[i]) * PW'(vel_gain_s);
      pdec_r[i] <= PW'(vel_r[i]) * PW'(decay_s);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (mode_r)
        MODE_FILTER: begin
          new_pos[i] = sat_c(PW'(pred_r[i]) + ((ppos_r[i] + RND) >>> 8));
          new_vel[i] = sat_c(PW'(vel_r[i]) + ((pvel_r[i] + RND) >>> 8));
        end
        MODE_COAST: begin
          new_pos[i] = sat_c(PW'(pred_r[i]));
          new_vel[i] = sat_c((pdec_r[i] + RND) >>> 8);
        end
        MODE_INIT: begin
          new_pos[i] = obs_r[i];
          new_vel[i] = '0;
        end
        default: begin
          new_pos[i] = pos_r[i];
          new_vel[i] = vel_r[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= UPD_IDLE;
      mode_r      <= MODE_HOLD;
      tracking_r  <= 1'b0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
      out_tv_r    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (idle && frm_ctl.valid) mode_r <= mode_cap;
      if (commit && has_result) out_valid_r <= 1'b1;
      else if (out_ready)       out_valid_r <= 1'b0;
      if (commit) begin
        for (int i = 0; i < 2; i++) begin
          pos_r[i] <= new_pos[i];
          vel_r[i] <= new_vel[i];
        end
        case (mode_r) inside
          MODE_INIT: begin
            tracking_r <= 1'b1;
            miss_r     <= '0;
          end
          MODE_DROP: begin
            tracking_r <= 1'b0;
            miss_r     <= miss_inc;
          end
          MODE_COAST, MODE_GATED: miss_r <= miss_inc;
          default: ;
        endcase
        if (has_result) begin
          out_tv_r <= (mode_r == MODE_COAST) || (mode_r == MODE_FILTER);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (idle && frm_ctl.valid) begin
      obs_r[0] <= frm_x;
      obs_r[1] <= frm_y;
    end
    if (commit && has_result) begin
      for (int i = 0; i < 2; i++) begin
        out_pos_r[i] <= new_pos[i];
        out_vel_r[i] <= new_vel[i];
      end
    end
  end

  assign trk.tracking    = tracking_r;
  assign trk.idle        = idle;
  assign est_x           = pos_r[0];
  assign est_y           = pos_r[1];
  assign done            = commit;
  assign out_valid       = out_valid_r;
  assign out_track_valid = out_tv_r;
  assign out_x           = out_pos_r[0];
  assign out_y           = out_pos_r[1];
  assign out_vx          = out_vel_r[0];
  assign out_vy          = out_vel_r[1];

  a_init_state: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && mode_r == MODE_INIT) |=> (tracking_r && miss_r == '0))
    else $error("initialization did not start a fresh track");

  a_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && mode_r == MODE_DROP) |=> (!tracking_r && out_valid_r && !out_tv_r))
    else $error("dropped track not reported as invalid");

  a_valid_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tv_r) |-> tracking_r)
    else $error("valid estimate reported without a track");

endmodule

>>> src/alpha_beta_nearest_target_tracker_core.sv
// ----------------------------------------------------------------------------
// alpha_beta_nearest_target_tracker_core
// Nearest-neighbor point association with an alpha-beta track filter.
// ----------------------------------------------------------------------------
// Point beats are taken one per clock while the input queue has room and flow
// through a three-stage squared distance pipeline into a running minimum. The
// beat that closes a frame (tlast) holds the read side of a four-entry input
// queue while it passes the distance pipeline and the residual, gain multiply
// and round/saturate steps of the update unit, since the next frame is
// measured against the new estimate. The input keeps accepting while the
// queue has room. One result beat leaves per frame end (tuser = track valid),
// except when a track is started on the nearest point; a result that waits on
// out_tready stalls only the next frame end. Point-less beats that do not
// close a frame are dropped on entry.
// ----------------------------------------------------------------------------
module alpha_beta_nearest_target_tracker_core
  import abt_pkg::*;
#(
  parameter  int COORD_WIDTH = 16,
  localparam int TDW         = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // point_x, point_y, self_x, self_y
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDW-1:0]        in_tdata,
  input  logic                  in_tuser,   // has_point
  input  logic                  in_tlast,   // frame_end
  // est_x, est_y, est_vx, est_vy
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDW-1:0]        out_tdata,
  output logic                  out_tuser,  // track_valid
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = dist_width(COORD_WIDTH);

  logic [GAIN_W-1:0]   pos_gain_r, vel_gain_r, vel_decay_r;
  logic [GATE_W-1:0]   gate_dist_r;
  logic [MISS_W-1:0]   miss_limit_r;
  logic [2*GATE_W-1:0] gate_sq_r;

  logic                 q_valid, q_has, q_last, pop;
  logic signed [CW-1:0] q_px, q_py, q_sx, q_sy;
  logic                 hold_r, hold_nxt;
  trk_status_t          trk;
  logic signed [CW-1:0] est_x, est_y;
  frame_ctl_t           frm_ctl;
  logic signed [CW-1:0] frm_x, frm_y;
  logic [DW-1:0]        frm_dist;
  logic                 upd_done;
  logic signed [CW-1:0] out_x, out_y, out_vx, out_vy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gain_r   <= POS_GAIN_RST;
      vel_gain_r   <= VEL_GAIN_RST;
      vel_decay_r  <= VEL_DECAY_RST;
      gate_dist_r  <= GATE_DIST_RST;
      miss_limit_r <= MISS_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_POS_GAIN:   pos_gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_VEL_GAIN:   vel_gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_VEL_DECAY:  vel_decay_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_GATE_DIST:  gate_dist_r  <= cfg_wdata[GATE_W-1:0];
        CFG_MISS_LIMIT: miss_limit_r <= cfg_wdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gate_sq_r <= gate_dist_r * gate_dist_r;
  end

  // reads stop after a frame end until the estimate is updated
  assign pop = q_valid & ~hold_r;

  always_comb begin
    hold_nxt = hold_r;
    if (pop && q_last) hold_nxt = 1'b1;
    else if (upd_done) hold_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= 1'b0;
    else        hold_r <= hold_nxt;
  end

  abt_front #(.COORD_WIDTH(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_px    (in_tdata[CW-1:0]),
    .in_py    (in_tdata[2*CW-1:CW]),
    .in_sx    (in_tdata[3*CW-1:2*CW]),
    .in_sy    (in_tdata[4*CW-1:3*CW]),
    .in_has   (in_tuser),
    .in_last  (in_tlast),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_px     (q_px),
    .q_py     (q_py),
    .q_sx     (q_sx),
    .q_sy     (q_sy),
    .q_has    (q_has),
    .q_last   (q_last)
  );

  abt_nearest #(.COORD_WIDTH(CW)) u_nearest (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .q_px     (q_px),
    .q_py     (q_py),
    .q_sx     (q_sx),
    .q_sy     (q_sy),
    .q_has    (q_has),
    .q_last   (q_last),
    .trk      (trk),
    .ref_x    (est_x),
    .ref_y    (est_y),
    .frm_ctl  (frm_ctl),
    .frm_x    (frm_x),
    .frm_y    (frm_y),
    .frm_dist (frm_dist)
  );

  abt_update #(.COORD_WIDTH(CW)) u_update (
    .clk             (clk),
    .rst_n           (rst_n),
    .frm_ctl         (frm_ctl),
    .frm_x           (frm_x),
    .frm_y           (frm_y),
    .frm_dist        (frm_dist),
    .pos_gain        (pos_gain_r),
    .vel_gain        (vel_gain_r),
    .vel_decay       (vel_decay_r),
    .gate_sq         (gate_sq_r),
    .miss_limit      (miss_limit_r),
    .trk             (trk),
    .est_x           (est_x),
    .est_y           (est_y),
    .done            (upd_done),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_track_valid (out_tuser),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_vx          (out_vx),
    .out_vy          (out_vy)
  );

  assign out_tdata = TDW'({out_vy, out_vx, out_y, out_x});

  a_frame_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frm_ctl.valid |-> (trk.idle && hold_r))
    else $error("frame record issued while the update unit is busy");

endmodule
